// ----- rtl/huffman_tree_walk_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// Huffman tree walk decoder assertion macros
// Shared concurrent assertion forms, clocked with a synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_WALK_DECODER_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_MACROS_SVH

// same-cycle implication
`define HTWD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HTWD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/htwd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwd_pkg
// Types and constants shared by the Huffman tree walk decoder modules
// ----------------------------------------------------------------------------
package htwd_pkg;

    localparam int IDX_W  = 9;
    localparam int SYM_W  = 8;
    localparam int POS_W  = 32;
    localparam int HDR_W  = 3;
    localparam int BIT_W  = 3;

    localparam logic [HDR_W-1:0] HDR_BYTES = 3'd4;
    localparam logic [BIT_W-1:0] LAST_BIT  = 3'd7;
    localparam logic [POS_W-1:0] BYTE_BITS = 32'd8;

    // request kinds on the input channel
    localparam logic FUNC_NODE = 1'b0;
    localparam logic FUNC_BYTE = 1'b1;

    // node table entry, left child in the lowest bits
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             leaf;
        logic [IDX_W-1:0] right;
        logic [IDX_W-1:0] left;
    } node_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CUR,
        ST_STEP,
        ST_EVAL,
        ST_FLUSH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic rd_cur;
        logic step;
        logic eval;
        logic finish;
        logic flush;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic go;
        logic at_end;
        logic is_leaf;
        logic last_bit;
        logic pend_valid;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/htwd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwd_ctrl
// Sequencer for the tree walk: one node table read per code bit
// ----------------------------------------------------------------------------
module htwd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output htwd_pkg::cmd_t    cmd,
    input  htwd_pkg::status_t st
);

    htwd_pkg::state_t state_reg;
    htwd_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= htwd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            htwd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (st.go) begin
                        state_next = htwd_pkg::ST_CUR;
                    end
                end
            end
            htwd_pkg::ST_CUR: begin
                cmd.rd_cur = 1'b1;
                state_next = htwd_pkg::ST_STEP;
            end
            htwd_pkg::ST_STEP: begin
                if (st.at_end) begin
                    cmd.finish = 1'b1;
                    state_next = htwd_pkg::ST_FLUSH;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = htwd_pkg::ST_EVAL;
                end
            end
            htwd_pkg::ST_EVAL: begin
                if (st.is_leaf) begin
                    // hold while an older symbol cannot move to the output
                    if (!st.pend_valid || st.out_free) begin
                        cmd.eval = 1'b1;
                        if (st.at_end) begin
                            cmd.finish = 1'b1;
                            state_next = htwd_pkg::ST_FLUSH;
                        end else if (st.last_bit) begin
                            state_next = htwd_pkg::ST_FLUSH;
                        end else begin
                            state_next = htwd_pkg::ST_CUR;
                        end
                    end
                end else begin
                    cmd.eval = 1'b1;
                    if (st.last_bit) begin
                        state_next = htwd_pkg::ST_FLUSH;
                    end else begin
                        state_next = htwd_pkg::ST_STEP;
                    end
                end
            end
            htwd_pkg::ST_FLUSH: begin
                if (!st.pend_valid || st.out_free) begin
                    cmd.flush  = 1'b1;
                    cmd.finish = st.at_end;
                    state_next = htwd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = htwd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/htwd_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwd_dp
// Node table, stream position registers, walk node and symbol output stage
// ----------------------------------------------------------------------------
module htwd_dp #(
    parameter int NODE_COUNT = 512
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  htwd_pkg::cmd_t               cmd,
    output htwd_pkg::status_t            st,
    input  logic                         cfg_wr_en,
    input  logic [htwd_pkg::IDX_W-1:0]   cfg_wr_data,
    input  logic                         in_func,
    input  logic [htwd_pkg::IDX_W-1:0]   in_node_index,
    input  logic [htwd_pkg::IDX_W-1:0]   in_left_child,
    input  logic [htwd_pkg::IDX_W-1:0]   in_right_child,
    input  logic                         in_is_leaf,
    input  logic [htwd_pkg::SYM_W-1:0]   in_leaf_symbol,
    input  logic [htwd_pkg::SYM_W-1:0]   in_stream_byte,
    input  logic                         in_stream_start,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [htwd_pkg::SYM_W-1:0]   out_symbol,
    output logic                         out_last,
    output logic                         out_done
);

    localparam int AW = $clog2(NODE_COUNT);

    // node table
    htwd_pkg::node_t node_mem [NODE_COUNT];
    htwd_pkg::node_t rd_data_reg;
    logic            rd_oor_reg;

    logic [htwd_pkg::IDX_W-1:0] root_reg;
    logic [htwd_pkg::IDX_W-1:0] walk_reg,   walk_next;
    logic [htwd_pkg::POS_W-1:0] pos_reg,    pos_next;
    logic [htwd_pkg::POS_W-1:0] end_reg,    end_next;
    logic [htwd_pkg::HDR_W-1:0] hdr_reg,    hdr_next;
    logic                       fin_reg,    fin_next;
    logic [htwd_pkg::SYM_W-1:0] shift_reg,  shift_next;
    logic [htwd_pkg::BIT_W-1:0] bcnt_reg,   bcnt_next;
    logic                       pend_v_reg, pend_v_next;
    logic [htwd_pkg::SYM_W-1:0] pend_sym_reg, pend_sym_next;
    logic                       pend_done_reg, pend_done_next;
    logic                       oval_reg,   oval_next;
    logic [htwd_pkg::SYM_W-1:0] osym_reg,   osym_next;
    logic                       olast_reg,  olast_next;
    logic                       odone_reg,  odone_next;

    htwd_pkg::node_t            cur;
    htwd_pkg::node_t            wr_entry;
    logic [htwd_pkg::IDX_W-1:0] child;
    logic [htwd_pkg::IDX_W-1:0] rd_idx;
    logic                       rd_en;
    logic                       wr_en;
    logic                       byte_in;
    logic [htwd_pkg::HDR_W-1:0] hdr_eff;
    logic [htwd_pkg::POS_W-1:0] pos_eff;
    logic [htwd_pkg::POS_W-1:0] end_eff;
    logic                       out_free;

    // entry read back, zero beyond the table
    assign cur   = rd_oor_reg ? '0 : rd_data_reg;
    assign child = shift_reg[htwd_pkg::SYM_W-1] ? cur.right : cur.left;

    assign rd_en  = cmd.rd_cur | cmd.step;
    assign rd_idx = cmd.step ? child : walk_reg;

    assign wr_en = cmd.accept && (in_func == htwd_pkg::FUNC_NODE)
                   && (32'(in_node_index) < NODE_COUNT);
    assign wr_entry = '{symbol: in_leaf_symbol, leaf: in_is_leaf,
                        right: in_right_child, left: in_left_child};

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[AW'(in_node_index)] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= node_mem[AW'(rd_idx)];
            rd_oor_reg  <= (32'(rd_idx) >= NODE_COUNT);
        end
    end

    // root register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= '0;
        end else if (cfg_wr_en) begin
            root_reg <= cfg_wr_data;
        end
    end

    // a stream start clears the stream state before the byte is used
    assign byte_in = (in_func == htwd_pkg::FUNC_BYTE);
    assign hdr_eff = in_stream_start ? '0 : hdr_reg;
    assign pos_eff = in_stream_start ? '0 : pos_reg;
    assign end_eff = in_stream_start ? '0 : end_reg;

    assign out_free = !oval_reg || out_ready;

    // status
    always_comb begin
        st            = '0;
        st.go         = byte_in && !in_stream_start && (hdr_reg == htwd_pkg::HDR_BYTES)
                        && !fin_reg;
        st.at_end     = (pos_reg >= end_reg);
        st.is_leaf    = cur.leaf;
        st.last_bit   = (bcnt_reg == htwd_pkg::LAST_BIT);
        st.pend_valid = pend_v_reg;
        st.out_free   = out_free;
    end

    // next values
    always_comb begin
        walk_next      = walk_reg;
        pos_next       = pos_reg;
        end_next       = end_reg;
        hdr_next       = hdr_reg;
        fin_next       = fin_reg;
        shift_next     = shift_reg;
        bcnt_next      = bcnt_reg;
        pend_v_next    = pend_v_reg;
        pend_sym_next  = pend_sym_reg;
        pend_done_next = pend_done_reg;
        oval_next      = oval_reg && !out_ready;
        osym_next      = osym_reg;
        olast_next     = olast_reg;
        odone_next     = odone_reg;

        // stream byte request
        if (cmd.accept && byte_in) begin
            if (in_stream_start) begin
                walk_next = root_reg;
                fin_next  = 1'b0;
            end
            pos_next   = pos_eff;
            end_next   = end_eff;
            hdr_next   = hdr_eff;
            shift_next = in_stream_byte;
            bcnt_next  = '0;
            if (hdr_eff < htwd_pkg::HDR_BYTES) begin
                end_next = {end_eff[htwd_pkg::POS_W-htwd_pkg::SYM_W-1:0], in_stream_byte};
                pos_next = pos_eff + htwd_pkg::BYTE_BITS;
                hdr_next = hdr_eff + 3'd1;
            end
        end

        // one code bit: move to the child
        if (cmd.step) begin
            walk_next  = child;
            pos_next   = pos_reg + 32'd1;
            shift_next = {shift_reg[htwd_pkg::SYM_W-2:0], 1'b0};
        end

        // child entry examined
        if (cmd.eval) begin
            bcnt_next = bcnt_reg + 3'd1;
            if (cur.leaf) begin
                if (pend_v_reg) begin
                    oval_next  = 1'b1;
                    osym_next  = pend_sym_reg;
                    olast_next = 1'b0;
                    odone_next = pend_done_reg;
                end
                pend_v_next    = 1'b1;
                pend_sym_next  = cur.symbol;
                pend_done_next = (pos_reg >= end_reg);
                walk_next      = root_reg;
            end
        end

        // end of byte: the held symbol is the last one
        if (cmd.flush && pend_v_reg) begin
            oval_next   = 1'b1;
            osym_next   = pend_sym_reg;
            olast_next  = 1'b1;
            odone_next  = pend_done_reg;
            pend_v_next = 1'b0;
        end

        if (cmd.finish) begin
            fin_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg   <= '0;
            pos_reg    <= '0;
            end_reg    <= '0;
            hdr_reg    <= '0;
            fin_reg    <= 1'b0;
            bcnt_reg   <= '0;
            pend_v_reg <= 1'b0;
            oval_reg   <= 1'b0;
        end else begin
            walk_reg   <= walk_next;
            pos_reg    <= pos_next;
            end_reg    <= end_next;
            hdr_reg    <= hdr_next;
            fin_reg    <= fin_next;
            bcnt_reg   <= bcnt_next;
            pend_v_reg <= pend_v_next;
            oval_reg   <= oval_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        shift_reg     <= shift_next;
        pend_sym_reg  <= pend_sym_next;
        pend_done_reg <= pend_done_next;
        osym_reg      <= osym_next;
        olast_reg     <= olast_next;
        odone_reg     <= odone_next;
    end

    assign out_valid  = oval_reg;
    assign out_symbol = osym_reg;
    assign out_last   = olast_reg;
    assign out_done   = odone_reg;

endmodule

// ----- rtl/huffman_tree_walk_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// Decodes a Huffman bit stream by walking a code tree held in a node table
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: tuser[0] selects a node table write (0) or a stream byte (1);
//   tuser[1] marks the first header byte of a new stream. The first four
//   bytes of a stream carry the big-endian end bit position.
//   m_ channel: one decoded symbol per transfer, tlast on the last symbol of
//   its input byte, tuser set when the symbol reached the end position.
//   cfg_wr_en/cfg_wr_data write the root index; write only while idle.
// Sequence:
//   node writes, header bytes and bytes after the end are taken while idle.
//   A coded byte reads the walk node, steps to and examines a child per bit and
//   ends in a flush; each bit is one registered read of the node table port.
//   Symbols leave through an output register; the next input request is
//   taken while the last symbol still waits there.
// Reset: aresetn clears the stream state as for a fresh stream and sets the
//   root index to 0; the node table keeps its contents and must be written.
// Stall: with output full and a symbol held, the walk holds at a leaf or flush.
// ----------------------------------------------------------------------------
`include "huffman_tree_walk_decoder_macros.svh"

module huffman_tree_walk_decoder #(
    parameter int NODE_COUNT = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,   // root_index
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,       // node_index, left_child, right_child,
                                       // is_leaf, leaf_symbol, stream_byte, zero pad
    input  logic [1:0]  s_tuser,       // func, stream_start
    // decoded symbols
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // symbol
    output logic        m_tlast,
    output logic        m_tuser        // stream_done
);

    htwd_pkg::cmd_t    cmd;
    htwd_pkg::status_t st;

    htwd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .st       (st)
    );

    htwd_dp #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .st              (st),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_func         (s_tuser[0]),
        .in_node_index   (s_tdata[8:0]),
        .in_left_child   (s_tdata[17:9]),
        .in_right_child  (s_tdata[26:18]),
        .in_is_leaf      (s_tdata[27]),
        .in_leaf_symbol  (s_tdata[35:28]),
        .in_stream_byte  (s_tdata[43:36]),
        .in_stream_start (s_tuser[1]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_symbol      (m_tdata),
        .out_last        (m_tlast),
        .out_done        (m_tuser)
    );

    // checks
    `HTWD_ASSERT_IMP(a_idle_no_pend, aclk, aresetn, s_tready, !st.pend_valid, "symbol held while idle")
    `HTWD_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.eval && st.is_leaf && st.pend_valid, st.out_free, "output register overwritten")
    `HTWD_ASSERT_NXT(a_flush_clears, aclk, aresetn, cmd.flush, !st.pend_valid, "held symbol left after flush")
    `HTWD_ASSERT_IMP(a_done_is_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast, "end symbol not last of byte")

endmodule
